// ----- hw/rtl/psrl_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// psrl_pkg: shared types and constants of the per-source rate limiter
// Slot table geometry, hash constants, check bits, reasons and records.
// ----------------------------------------------------------------------------
package psrl_pkg;

	localparam int SLOT_COUNT = 4096;
	localparam int SLOT_W     = $clog2(SLOT_COUNT);

	// hash multipliers and tag seed modifier
	localparam logic [31:0] HASH_C1  = 32'h9e3779b1;
	localparam logic [31:0] HASH_C2  = 32'h85ebca6b;
	localparam logic [31:0] HASH_C3  = 32'hc2b2ae35;
	localparam logic [31:0] TAG_SALT = 32'h5bf03635;

	// check mask bits
	localparam int CHK_TOKENS = 0;
	localparam int CHK_SYN    = 1;
	localparam int CHK_ICMP   = 2;
	localparam int CHK_OOB    = 3;
	localparam int CHK_CONN   = 4;

	// verdict codes
	localparam logic [2:0] RSN_PASS = 3'd0;
	localparam logic [2:0] RSN_RATE = 3'd1;
	localparam logic [2:0] RSN_SYN  = 3'd2;
	localparam logic [2:0] RSN_ICMP = 3'd3;
	localparam logic [2:0] RSN_OOB  = 3'd4;
	localparam logic [2:0] RSN_CONN = 3'd5;

	// register indexes
	localparam logic [2:0] REG_SEED   = 3'd0;
	localparam logic [2:0] REG_BURST  = 3'd1;
	localparam logic [2:0] REG_REFILL = 3'd2;
	localparam logic [2:0] REG_SYN    = 3'd3;
	localparam logic [2:0] REG_ICMP   = 3'd4;
	localparam logic [2:0] REG_OOB    = 3'd5;
	localparam logic [2:0] REG_WIN    = 3'd6;
	localparam logic [2:0] REG_QUOTA  = 3'd7;

	typedef struct packed {
		logic [31:0] mix_seed;
		logic [23:0] bucket_burst;
		logic [63:0] refill_period_ns;
		logic [63:0] syn_gap_ns;
		logic [63:0] icmp_gap_ns;
		logic [63:0] oob_gap_ns;
		logic [63:0] conn_window_len_ns;
		logic [15:0] conn_quota;
	} cfg_t;

	// classified transaction passed from front to back
	typedef struct packed {
		logic [SLOT_W-1:0] idx;
		logic [31:0]       tag;
		logic [63:0]       now;
		logic [4:0]        mask;
	} item_t;

	// one slot of the table
	typedef struct packed {
		logic [31:0] tag;
		logic [23:0] tokens;
		logic [63:0] refill_time;
		logic [63:0] syn_time;
		logic [63:0] icmp_time;
		logic [63:0] oob_time;
		logic [63:0] window_start;
		logic [15:0] conn_tally;
	} entry_t;

endpackage

// ----- hw/rtl/psrl_fifo.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// psrl_fifo: two-entry queue between front and back
// Decouples hashing from slot processing so each side stalls on its own.
// ----------------------------------------------------------------------------
module psrl_fifo import psrl_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  push,
	input  item_t push_data,
	output logic  full,
	input  logic  pop,
	output item_t pop_data,
	output logic  empty
);

	item_t      buf_q [2];
	logic       wp_q, rp_q;
	logic [1:0] cnt_q;

	assign full     = (cnt_q == 2'd2);
	assign empty    = (cnt_q == 2'd0);
	assign pop_data = buf_q[rp_q];

	// storage
	always_ff @(posedge clk) begin
		if (push && !full) buf_q[wp_q] <= push_data;
	end

	// pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= 1'b0;
			rp_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push && !full) wp_q <= ~wp_q;
			if (pop && !empty) rp_q <= ~rp_q;
			case ({push && !full, pop && !empty})
				2'b10:   cnt_q <= cnt_q + 2'd1;
				2'b01:   cnt_q <= cnt_q - 2'd1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

endmodule

// ----- hw/rtl/psrl_front.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// psrl_front: input stage and source hashing
// Accepts a transaction, runs the slot and tag hashes on one shared
// multiplier (four steps per hash) and queues the classified transaction.
// ----------------------------------------------------------------------------
module psrl_front import psrl_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  cfg_t        cfg,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [31:0] src_word0,
	input  logic [31:0] src_word1,
	input  logic [31:0] src_word2,
	input  logic [31:0] src_word3,
	input  logic [63:0] now_ns,
	input  logic [4:0]  check_mask,
	output logic        push,
	output item_t       push_data,
	input  logic        full
);

	typedef enum logic [1:0] {F_IDLE, F_HASH, F_PUSH} fstate_t;

	fstate_t           state_q;
	logic [1:0]        ph_q;
	logic              sel_q;
	logic [31:0]       w0_q, w1_q, w2_q, w3_q;
	logic [63:0]       now_q;
	logic [4:0]        mask_q;
	logic [31:0]       p_q;
	logic [SLOT_W-1:0] idx_q;
	logic [31:0]       tag_q;

	logic [31:0] seed_sel, mul_a, mul_c, mul_p, h_fin;

	assign in_stall  = (state_q != F_IDLE);
	assign push      = (state_q == F_PUSH);
	assign push_data = '{idx: idx_q, tag: tag_q, now: now_q, mask: mask_q};

	// mixing step feeding the shared multiplier
	always_comb begin
		seed_sel = sel_q ? (cfg.mix_seed ^ TAG_SALT) : cfg.mix_seed;
		h_fin    = p_q ^ (p_q >> 16);
		case (ph_q)
			2'd0: begin
				mul_a = seed_sel ^ w0_q;
				mul_c = HASH_C1;
			end
			2'd1: begin
				mul_a = (p_q ^ (p_q >> 15)) + w1_q;
				mul_c = HASH_C2;
			end
			default: begin
				mul_a = (p_q ^ (p_q >> 13)) + (w2_q ^ w3_q);
				mul_c = HASH_C3;
			end
		endcase
		mul_p = mul_a * mul_c;
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= F_IDLE;
			ph_q    <= 2'd0;
			sel_q   <= 1'b0;
		end else begin
			unique case (state_q)
				F_IDLE: begin
					if (in_valid) begin
						state_q <= F_HASH;
						ph_q    <= 2'd0;
						sel_q   <= 1'b0;
					end
				end
				F_HASH: begin
					if (ph_q == 2'd3) begin
						ph_q <= 2'd0;
						if (!sel_q) sel_q <= 1'b1;
						else state_q <= F_PUSH;
					end else begin
						ph_q <= ph_q + 2'd1;
					end
				end
				F_PUSH: begin
					if (!full) state_q <= F_IDLE;
				end
				default: state_q <= F_IDLE;
			endcase
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (state_q == F_IDLE && in_valid) begin
			w0_q   <= src_word0;
			w1_q   <= src_word1;
			w2_q   <= src_word2;
			w3_q   <= src_word3;
			now_q  <= now_ns;
			mask_q <= check_mask;
		end
		if (state_q == F_HASH) begin
			if (ph_q != 2'd3) p_q <= mul_p;
			else if (!sel_q) idx_q <= h_fin[SLOT_W-1:0];
			else tag_q <= h_fin | 32'd1;
		end
	end

endmodule

// ----- hw/rtl/psrl_back.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// psrl_back: slot table and check engine
// Reads the slot, claims it on a tag miss, refills tokens through a
// bit-serial divider, runs the checks, writes the slot back and
// registers the verdict.
// ----------------------------------------------------------------------------
module psrl_back import psrl_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  cfg_t       cfg,
	output logic       pop,
	input  item_t      pop_data,
	input  logic       empty,
	output logic       out_valid,
	input  logic       out_stall,
	output logic [2:0] verdict_reason
);

	typedef enum logic [2:0] {
		B_CLEAR, B_IDLE, B_READ, B_LOOK, B_DIV, B_CHECK, B_OUT
	} bstate_t;

	bstate_t           state_q;
	logic [SLOT_W-1:0] clr_q;
	item_t             it_q;
	entry_t            mem [SLOT_COUNT];
	entry_t            rd_q;
	entry_t            cur_q;
	logic              use_div_q;
	logic [63:0]       dvd_q;
	logic [63:0]       rem_q;
	logic [6:0]        cnt_q;
	logic [2:0]        reason_q;
	logic              out_valid_q;
	logic [2:0]        verdict_q;

	entry_t      look_e, nxt_e;
	logic [2:0]  rsn;
	logic [64:0] rem_sh;
	logic        q_bit;
	logic [23:0] add;
	logic [24:0] sum;
	logic [23:0] tok;
	logic        mem_we;
	logic [SLOT_W-1:0] mem_wa;
	entry_t      mem_wd;

	assign pop            = (state_q == B_IDLE) && !empty;
	assign out_valid      = out_valid_q;
	assign verdict_reason = verdict_q;

	// tag compare and claim
	always_comb begin
		look_e = rd_q;
		if (rd_q.tag != it_q.tag) begin
			look_e = '{tag: it_q.tag, tokens: cfg.bucket_burst, refill_time: it_q.now,
				syn_time: 64'd0, icmp_time: 64'd0, oob_time: 64'd0,
				window_start: it_q.now, conn_tally: 16'd0};
		end
	end

	// one restoring divide step
	always_comb begin
		rem_sh = {rem_q, dvd_q[63]};
		q_bit  = (rem_sh >= {1'b0, cfg.refill_period_ns});
	end

	// checks in fixed order; first failure ends the run
	always_comb begin
		nxt_e = cur_q;
		rsn   = RSN_PASS;
		add   = 24'd0;
		sum   = 25'd0;
		tok   = cur_q.tokens;
		if (it_q.mask[CHK_TOKENS]) begin
			if (use_div_q) begin
				add = (dvd_q > {40'd0, cfg.bucket_burst}) ? cfg.bucket_burst : dvd_q[23:0];
				if (add != 24'd0) begin
					sum = {1'b0, cur_q.tokens} + {1'b0, add};
					tok = (sum > {1'b0, cfg.bucket_burst}) ? cfg.bucket_burst : sum[23:0];
					nxt_e.refill_time = it_q.now;
				end
			end
			if (tok == 24'd0) begin
				rsn = RSN_RATE;
			end else begin
				tok = tok - 24'd1;
			end
			nxt_e.tokens = tok;
		end
		if (rsn == RSN_PASS && it_q.mask[CHK_SYN]) begin
			if (cur_q.syn_time != 64'd0 && (it_q.now - cur_q.syn_time) < cfg.syn_gap_ns)
				rsn = RSN_SYN;
			else
				nxt_e.syn_time = it_q.now;
		end
		if (rsn == RSN_PASS && it_q.mask[CHK_ICMP]) begin
			if (cur_q.icmp_time != 64'd0 && (it_q.now - cur_q.icmp_time) < cfg.icmp_gap_ns)
				rsn = RSN_ICMP;
			else
				nxt_e.icmp_time = it_q.now;
		end
		if (rsn == RSN_PASS && it_q.mask[CHK_OOB]) begin
			if (cur_q.oob_time != 64'd0 && (it_q.now - cur_q.oob_time) < cfg.oob_gap_ns)
				rsn = RSN_OOB;
			else
				nxt_e.oob_time = it_q.now;
		end
		if (rsn == RSN_PASS && it_q.mask[CHK_CONN]) begin
			if ((it_q.now - cur_q.window_start) >= cfg.conn_window_len_ns) begin
				nxt_e.window_start = it_q.now;
				nxt_e.conn_tally   = 16'd0;
			end
			if (cfg.conn_quota != 16'd0 && nxt_e.conn_tally >= cfg.conn_quota)
				rsn = RSN_CONN;
			else if (nxt_e.conn_tally != 16'hFFFF)
				nxt_e.conn_tally = nxt_e.conn_tally + 16'd1;
		end
	end

	// table write port: clearing pass or slot write-back
	always_comb begin
		mem_we = 1'b0;
		mem_wa = it_q.idx;
		mem_wd = nxt_e;
		if (state_q == B_CLEAR) begin
			mem_we = 1'b1;
			mem_wa = clr_q;
			mem_wd = '0;
		end else if (state_q == B_CHECK) begin
			mem_we = 1'b1;
		end
	end

	// slot table
	always_ff @(posedge clk) begin
		if (mem_we) mem[mem_wa] <= mem_wd;
		rd_q <= mem[it_q.idx];
	end

	// control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= B_CLEAR;
			clr_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			// result register: load a new verdict or drop the one just taken
			if (state_q == B_OUT && (!out_valid_q || !out_stall))
				out_valid_q <= 1'b1;
			else if (out_valid_q && !out_stall)
				out_valid_q <= 1'b0;
			unique case (state_q)
				B_CLEAR: begin
					clr_q <= clr_q + SLOT_W'(1);
					if (clr_q == SLOT_W'(SLOT_COUNT - 1)) state_q <= B_IDLE;
				end
				B_IDLE: begin
					if (!empty) state_q <= B_READ;
				end
				B_READ:  state_q <= B_LOOK;
				B_LOOK: begin
					if (it_q.mask[CHK_TOKENS] && cfg.refill_period_ns != 64'd0)
						state_q <= B_DIV;
					else
						state_q <= B_CHECK;
				end
				B_DIV: begin
					if (cnt_q == 7'd63) state_q <= B_CHECK;
				end
				B_CHECK: state_q <= B_OUT;
				B_OUT: begin
					if (!out_valid_q || !out_stall) state_q <= B_IDLE;
				end
				default: state_q <= B_IDLE;
			endcase
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		case (state_q)
			B_IDLE: begin
				if (!empty) it_q <= pop_data;
			end
			B_LOOK: begin
				cur_q     <= look_e;
				dvd_q     <= it_q.now - look_e.refill_time;
				rem_q     <= 64'd0;
				cnt_q     <= 7'd0;
				use_div_q <= it_q.mask[CHK_TOKENS] && (cfg.refill_period_ns != 64'd0);
			end
			B_DIV: begin
				rem_q <= q_bit ? 64'(rem_sh - {1'b0, cfg.refill_period_ns}) : rem_sh[63:0];
				dvd_q <= {dvd_q[62:0], q_bit};
				cnt_q <= cnt_q + 7'd1;
			end
			B_CHECK: reason_q <= rsn;
			B_OUT: begin
				if (!out_valid_q || !out_stall) verdict_q <= reason_q;
			end
			default: ;
		endcase
	end

endmodule

// ----- hw/rtl/per_source_rate_limiter.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// per_source_rate_limiter: hashed per-source token bucket and gap limiter
// Top level with the register file, hashing front, queue and slot back end.
// ----------------------------------------------------------------------------
// After reset the back end sweeps the 4096-slot table once, one slot per
// cycle; meanwhile the front still takes up to three transactions (one in
// the front, two in the queue) and holds them until the sweep is done.
// Register writes are taken at any time. The front holds a transaction
// after accepting it for eight hashing steps (four per hash), then the
// queue push, which waits while the queue is full, and takes no new
// transaction until the push is done. The back takes each transaction
// through pop, table read, tag compare, checks and write-back, and
// verdict, which waits while out_stall holds the previous result, with a
// divide pass before the checks when the token check runs with a nonzero
// refill period, since the refill quotient comes from a divider that
// produces one bit per cycle. The two sides overlap through a two-entry
// queue, so the sustained rate is set by the front, or by the back with
// token refill. Registers sit at byte address 8*i on a 64-bit APB port
// and may only change while idle.
module per_source_rate_limiter import psrl_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [5:0]  paddr,
	input  logic [63:0] pwdata,
	output logic [63:0] prdata,
	output logic        pready,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [31:0] src_word0,
	input  logic [31:0] src_word1,
	input  logic [31:0] src_word2,
	input  logic [31:0] src_word3,
	input  logic [63:0] now_ns,
	input  logic [4:0]  check_mask,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [2:0]  verdict_reason
);

	cfg_t  cfg_q;
	logic  q_push, q_full, q_pop, q_empty;
	item_t q_wdata, q_rdata;
	logic [2:0] reg_sel;

	assign pready  = 1'b1;
	assign reg_sel = paddr[5:3];

	// register writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '{mix_seed: 32'd0, bucket_burst: 24'd64, refill_period_ns: 64'd0,
				syn_gap_ns: 64'd0, icmp_gap_ns: 64'd0, oob_gap_ns: 64'd0,
				conn_window_len_ns: 64'd0, conn_quota: 16'd0};
		end else if (psel && penable && pwrite) begin
			unique case (reg_sel)
				REG_SEED:   cfg_q.mix_seed           <= pwdata[31:0];
				REG_BURST:  cfg_q.bucket_burst       <= pwdata[23:0];
				REG_REFILL: cfg_q.refill_period_ns   <= pwdata;
				REG_SYN:    cfg_q.syn_gap_ns         <= pwdata;
				REG_ICMP:   cfg_q.icmp_gap_ns        <= pwdata;
				REG_OOB:    cfg_q.oob_gap_ns         <= pwdata;
				REG_WIN:    cfg_q.conn_window_len_ns <= pwdata;
				REG_QUOTA:  cfg_q.conn_quota         <= pwdata[15:0];
				default: ;
			endcase
		end
	end

	// register reads
	always_comb begin
		unique case (reg_sel)
			REG_SEED:   prdata = {32'd0, cfg_q.mix_seed};
			REG_BURST:  prdata = {40'd0, cfg_q.bucket_burst};
			REG_REFILL: prdata = cfg_q.refill_period_ns;
			REG_SYN:    prdata = cfg_q.syn_gap_ns;
			REG_ICMP:   prdata = cfg_q.icmp_gap_ns;
			REG_OOB:    prdata = cfg_q.oob_gap_ns;
			REG_WIN:    prdata = cfg_q.conn_window_len_ns;
			REG_QUOTA:  prdata = {48'd0, cfg_q.conn_quota};
			default:    prdata = 64'd0;
		endcase
	end

	psrl_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg_q),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.src_word0  (src_word0),
		.src_word1  (src_word1),
		.src_word2  (src_word2),
		.src_word3  (src_word3),
		.now_ns     (now_ns),
		.check_mask (check_mask),
		.push       (q_push),
		.push_data  (q_wdata),
		.full       (q_full)
	);

	psrl_fifo u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (q_push),
		.push_data (q_wdata),
		.full      (q_full),
		.pop       (q_pop),
		.pop_data  (q_rdata),
		.empty     (q_empty)
	);

	psrl_back u_back (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg            (cfg_q),
		.pop            (q_pop),
		.pop_data       (q_rdata),
		.empty          (q_empty),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.verdict_reason (verdict_reason)
	);

endmodule

// ----- tb/tb_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for the per-source rate limiter
// Drives address, time and check-mask transactions with random gaps and
// output back-pressure, predicts each verdict from a software copy of the
// slot table, and sweeps the registers through several settings.
// ----------------------------------------------------------------------------

class verdict_board;
	// predictor configuration
	logic [31:0] seed;
	logic [23:0] burst;
	logic [63:0] refill, syn_gap, icmp_gap, oob_gap, win_len;
	logic [15:0] quota;
	// slot table copy
	logic [31:0] tag_q      [psrl_pkg::SLOT_COUNT];
	logic [23:0] tokens_q   [psrl_pkg::SLOT_COUNT];
	logic [63:0] refill_t   [psrl_pkg::SLOT_COUNT];
	logic [63:0] syn_t      [psrl_pkg::SLOT_COUNT];
	logic [63:0] icmp_t     [psrl_pkg::SLOT_COUNT];
	logic [63:0] oob_t      [psrl_pkg::SLOT_COUNT];
	logic [63:0] win_start  [psrl_pkg::SLOT_COUNT];
	logic [15:0] conn_cnt   [psrl_pkg::SLOT_COUNT];
	logic [2:0]  pending_verdicts[$];
	int errors;
	int checked;

	function new();
		seed = 0; burst = 64; refill = 0; syn_gap = 0; icmp_gap = 0;
		oob_gap = 0; win_len = 0; quota = 0; errors = 0; checked = 0;
		foreach (tag_q[i]) tag_q[i] = '0;
	endfunction

	function void set_reg(logic [2:0] idx, logic [63:0] v);
		case (idx)
			psrl_pkg::REG_SEED:   seed = v[31:0];
			psrl_pkg::REG_BURST:  burst = v[23:0];
			psrl_pkg::REG_REFILL: refill = v;
			psrl_pkg::REG_SYN:    syn_gap = v;
			psrl_pkg::REG_ICMP:   icmp_gap = v;
			psrl_pkg::REG_OOB:    oob_gap = v;
			psrl_pkg::REG_WIN:    win_len = v;
			psrl_pkg::REG_QUOTA:  quota = v[15:0];
			default: ;
		endcase
	endfunction

	function logic [31:0] mix(logic [31:0] w0, w1, w2, w3, logic [31:0] s);
		logic [31:0] h;
		h = s ^ w0;
		h = h * psrl_pkg::HASH_C1;
		h = h ^ (h >> 15);
		h = h + w1;
		h = h * psrl_pkg::HASH_C2;
		h = h ^ (h >> 13);
		h = h + (w2 ^ w3);
		h = h * psrl_pkg::HASH_C3;
		h = h ^ (h >> 16);
		return h;
	endfunction

	// minimum-interval rule on one event time; 1 on accept
	function bit gap_pass(ref logic [63:0] last, input logic [63:0] now, gap);
		if (last != 64'd0 && (now - last) < gap) return 0;
		last = now;
		return 1;
	endfunction

	// note an accepted input and queue its verdict
	function void note_input(logic [31:0] w0, w1, w2, w3, logic [63:0] now,
			logic [4:0] chk);
		logic [31:0] h;
		logic [psrl_pkg::SLOT_W-1:0] s;
		logic [31:0] t;
		logic [63:0] add;
		logic [24:0] sum;
		logic [2:0]  rsn;
		h = mix(w0, w1, w2, w3, seed);
		s = h[psrl_pkg::SLOT_W-1:0];
		t = mix(w0, w1, w2, w3, seed ^ psrl_pkg::TAG_SALT) | 32'd1;
		rsn = psrl_pkg::RSN_PASS;
		// tag mismatch claims the slot
		if (tag_q[s] != t) begin
			tag_q[s] = t; tokens_q[s] = burst; refill_t[s] = now;
			syn_t[s] = 0; icmp_t[s] = 0; oob_t[s] = 0;
			win_start[s] = now; conn_cnt[s] = 0;
		end
		if (chk[psrl_pkg::CHK_TOKENS]) begin
			if (refill != 64'd0) begin
				add = (now - refill_t[s]) / refill;
				if (add > {40'd0, burst}) add = {40'd0, burst};
				if (add != 64'd0) begin
					sum = {1'b0, tokens_q[s]} + add[24:0];
					tokens_q[s] = (sum > {1'b0, burst}) ? burst : sum[23:0];
					refill_t[s] = now;
				end
			end
			if (tokens_q[s] == 24'd0) rsn = psrl_pkg::RSN_RATE;
			else tokens_q[s] = tokens_q[s] - 24'd1;
		end
		if (rsn == psrl_pkg::RSN_PASS && chk[psrl_pkg::CHK_SYN] &&
				!gap_pass(syn_t[s], now, syn_gap)) rsn = psrl_pkg::RSN_SYN;
		if (rsn == psrl_pkg::RSN_PASS && chk[psrl_pkg::CHK_ICMP] &&
				!gap_pass(icmp_t[s], now, icmp_gap)) rsn = psrl_pkg::RSN_ICMP;
		if (rsn == psrl_pkg::RSN_PASS && chk[psrl_pkg::CHK_OOB] &&
				!gap_pass(oob_t[s], now, oob_gap)) rsn = psrl_pkg::RSN_OOB;
		if (rsn == psrl_pkg::RSN_PASS && chk[psrl_pkg::CHK_CONN]) begin
			if ((now - win_start[s]) >= win_len) begin
				win_start[s] = now; conn_cnt[s] = 0;
			end
			if (quota != 16'd0 && conn_cnt[s] >= quota) rsn = psrl_pkg::RSN_CONN;
			else if (conn_cnt[s] != 16'hffff) conn_cnt[s] = conn_cnt[s] + 16'd1;
		end
		pending_verdicts.push_back(rsn);
	endfunction

	// compare one accepted result against the oldest expectation
	function void check_result(logic [2:0] got);
		logic [2:0] exp_v;
		if (pending_verdicts.size() == 0) begin
			$error("unexpected verdict_reason %0d", got);
			errors++;
			return;
		end
		exp_v = pending_verdicts.pop_front();
		checked++;
		if (got !== exp_v) begin
			$error("verdict_reason: expected %0d, actual %0d", exp_v, got);
			errors++;
		end
	endfunction
endclass

module tb_top;
	import psrl_pkg::*;

	logic        clk = 0;
	logic        arst_n = 0;
	logic        psel = 0, penable = 0, pwrite = 0;
	logic [5:0]  paddr = '0;
	logic [63:0] pwdata = '0;
	logic [63:0] prdata;
	logic        pready;
	logic        in_valid = 0;
	logic        in_stall;
	logic [31:0] src_word0 = '0, src_word1 = '0, src_word2 = '0, src_word3 = '0;
	logic [63:0] now_ns = '0;
	logic [4:0]  check_mask = '0;
	logic        out_valid;
	logic        out_stall = 0;
	logic [2:0]  verdict_reason;

	verdict_board board;
	bit   quiet_tail;       // no idling on either side
	bit   long_hold;        // receiver holds off for a long stretch
	int   idle_cycles;
	int   hold_left = 0;    // remaining cycles of a short receiver burst
	int   sent;
	logic [63:0] clock_ns;  // advancing time base for random traffic
	logic [31:0] src_pool[16][4];

	per_source_rate_limiter dut (.*);

	always begin
		#5 clk = 1;
		#5 clk = 0;
	end

	// result side: check and throttle
	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) board.check_result(verdict_reason);
	end

	always @(posedge clk) begin
		if (long_hold) begin
			out_stall <= 1;
		end else if (hold_left > 0) begin
			out_stall <= 1;
			hold_left--;
		end else if (!quiet_tail && $urandom_range(0, 5) == 0) begin
			out_stall <= 1;
			hold_left = $urandom_range(0, 2);
		end else begin
			out_stall <= 0;
		end
	end

	// watchdog: cycles with no transaction on either channel
	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles <= 0;
		else idle_cycles <= idle_cycles + 1;
		if (idle_cycles > 20000) begin
			$display("tb_top failed");
			$finish;
		end
	end

	task automatic reg_write(logic [2:0] idx, logic [63:0] v);
		@(posedge clk);
		psel <= 1; penable <= 0; pwrite <= 1; paddr <= {idx, 3'b000}; pwdata <= v;
		@(posedge clk);
		penable <= 1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		psel <= 0; penable <= 0; pwrite <= 0;
		board.set_reg(idx, v);
	endtask

	// valid stays high between back-to-back transactions, drops only for a gap
	task automatic send(logic [31:0] w0, w1, w2, w3, logic [63:0] now,
			logic [4:0] chk);
		int gap;
		if (!quiet_tail && $urandom_range(0, 3) == 0) begin
			gap = $urandom_range(1, 3);
			in_valid <= 0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1;
		src_word0 <= w0; src_word1 <= w1; src_word2 <= w2; src_word3 <= w3;
		now_ns <= now; check_mask <= chk;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		board.note_input(w0, w1, w2, w3, now, chk);
		sent++;
	endtask

	// idle point: all verdicts in, then the back end's longest latency
	task automatic drain();
		in_valid <= 0;
		while (board.pending_verdicts.size() != 0) @(posedge clk);
		repeat (100) @(posedge clk);
	endtask

	task automatic random_traffic(int count);
		int p;
		logic [63:0] t;
		for (int k = 0; k < count; k++) begin
			clock_ns = clock_ns + 64'($urandom_range(0, 400));
			t = clock_ns;
			p = $urandom_range(0, 15);
			if ($urandom_range(0, 9) == 0)
				send($urandom, $urandom, $urandom, $urandom,
					{$urandom, $urandom}, 5'($urandom_range(0, 31)));
			else
				send(src_pool[p][0], src_pool[p][1], src_pool[p][2], src_pool[p][3],
					t, 5'($urandom_range(0, 31)));
		end
	endtask

	initial begin
		board = new();
		quiet_tail = 0; long_hold = 0; idle_cycles = 0; sent = 0;
		clock_ns = 64'd1000;
		foreach (src_pool[i]) foreach (src_pool[i][j]) src_pool[i][j] = $urandom;
		repeat (2) @(posedge clk);
		arst_n <= 1;

		// directed: reset settings, field extremes, every check
		send('0, '0, '0, '0, '0, 5'h00);
		send('1, '1, '1, '1, '1, 5'h1f);
		send('1, '1, '1, '1, '1, 5'h1f);
		send('0, '0, '0, '0, 64'd0, 5'h02);   // accept at time zero
		send('0, '0, '0, '0, 64'd5, 5'h02);
		drain();
		reg_write(REG_SEED, 64'hffffffff);
		reg_write(REG_BURST, 64'd2);
		reg_write(REG_REFILL, 64'd0);
		reg_write(REG_SYN, 64'd100);
		reg_write(REG_ICMP, 64'd100);
		reg_write(REG_OOB, 64'd100);
		reg_write(REG_WIN, 64'd1000);
		reg_write(REG_QUOTA, 64'd1);
		// bucket drains, each gap limit trips, conn quota trips
		for (int k = 0; k < 3; k++) send(32'h11, 32'h22, 32'h33, 32'h44, 64'd10, 5'h01);
		send(32'h11, 32'h22, 32'h33, 32'h44, 64'd20, 5'h00);
		send(32'h55, 32'h0, 32'h0, 32'h0, 64'd10, 5'h02);
		send(32'h55, 32'h0, 32'h0, 32'h0, 64'd50, 5'h02);
		send(32'h55, 32'h0, 32'h0, 32'h0, 64'd60, 5'h04);
		send(32'h55, 32'h0, 32'h0, 32'h0, 64'd70, 5'h04);
		send(32'h55, 32'h0, 32'h0, 32'h0, 64'd80, 5'h08);
		send(32'h55, 32'h0, 32'h0, 32'h0, 64'd90, 5'h08);
		send(32'h55, 32'h0, 32'h0, 32'h0, 64'd95, 5'h10);
		send(32'h55, 32'h0, 32'h0, 32'h0, 64'd96, 5'h10);
		send(32'h55, 32'h0, 32'h0, 32'h0, 64'd2000, 5'h10);
		send(32'h55, 32'h0, 32'h0, 32'h0, 64'd2001, 5'h1e); // gap checks pass, conn quota trips
		drain();

		// lowered burst with refill, then refill at the extreme period
		reg_write(REG_BURST, 64'd40);
		reg_write(REG_REFILL, 64'd7);
		random_traffic(80);
		drain();
		reg_write(REG_BURST, 64'd3);
		random_traffic(60);
		drain();
		reg_write(REG_SEED, 64'($urandom));
		reg_write(REG_BURST, 64'hffffff);
		reg_write(REG_REFILL, 64'hffffffffffffffff);
		reg_write(REG_SYN, 64'hffffffffffffffff);
		reg_write(REG_ICMP, 64'd0);
		reg_write(REG_OOB, 64'd300);
		reg_write(REG_WIN, 64'hffffffffffffffff);
		reg_write(REG_QUOTA, 64'hffff);
		random_traffic(60);
		drain();

		// fill the block while the receiver holds off
		reg_write(REG_REFILL, 64'd0);
		reg_write(REG_WIN, 64'd0);
		reg_write(REG_QUOTA, 64'd0);
		long_hold = 1;
		fork
			begin
				repeat (200) @(posedge clk);
				long_hold = 0;
			end
			random_traffic(20);
		join
		drain();

		reg_write(REG_BURST, 64'd8);
		reg_write(REG_REFILL, 64'd50);
		reg_write(REG_SYN, 64'd150);
		reg_write(REG_WIN, 64'd800);
		reg_write(REG_QUOTA, 64'd3);
		random_traffic(120);
		quiet_tail = 1;
		random_traffic(60);

		drain();
		$display("covered %0d transactions and %0d verdicts across several register settings",
			sent, board.checked);
		if (board.errors == 0 && board.pending_verdicts.size() == 0)
			$display("tb_top passed");
		else
			$display("tb_top failed");
		$finish;
	end
endmodule
